// ----- design/wf3_pkg.sv -----
// Shared types and constants for the 3x3 RGB window filter.
// No dependencies; imported by the line store, the channel lane and the top level.
package wf3_pkg;

  localparam int PIX_W   = 24;          // one packed BGR pixel
  localparam int CH_W    = 8;           // one color channel
  localparam int N_CH    = 3;           // blue, green, red
  localparam int LS_W    = 2 * PIX_W;   // older row and newer row side by side
  localparam int SUM_W   = 13;          // signed window sum, -1020 .. 2295
  localparam int ROW_W   = 12;          // row counter
  localparam int OX_W    = 10;          // reported column
  localparam int OY_W    = 12;          // reported row
  localparam int CFG_W   = 13;          // widest configuration register
  localparam int CFG_A_W = 2;           // configuration register index
  localparam int IW_W    = 11;          // image_width register
  localparam int IH_W    = 13;          // image_height register

  localparam logic [IW_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IH_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [IH_W-1:0] MIN_DIM_H  = 13'd3;
  localparam logic [IH_W-1:0] MAX_HEIGHT = 13'd4096;

  // floor(x / 9) == (x * 7282) >> 16 for every x below 2296.
  localparam logic [12:0] BOX_RECIP  = 13'd7282;
  localparam int          BOX_SHIFT  = 16;

  typedef enum logic [1:0] {
    MODE_BOX     = 2'd0,
    MODE_SOBEL_X = 2'd1,
    MODE_SOBEL_Y = 2'd2,
    MODE_LAPL    = 2'd3
  } filt_mode_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  // One channel's 3x3 window, entry r*3+c: r = 0 top row, c = 0 left column.
  typedef logic [8:0][CH_W-1:0] win_t;

endpackage

// ----- design/wf3_line_store.sv -----
// Two line stores held as one wide memory (older row high, newer row low).
// Depends on wf3_pkg; clears itself after reset, one entry per cycle.
module wf3_line_store #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [wf3_pkg::LS_W-1:0]  rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [wf3_pkg::LS_W-1:0]  wr_data,
  output logic                      ready
);
  import wf3_pkg::*;

  logic [LS_W-1:0] mem [MAX_WIDTH];
  logic [LS_W-1:0] rd_data_r;
  logic            clr_busy_r;
  logic [AW-1:0]   clr_addr_r;
  logic [AW-1:0]   clr_addr_nxt;

  assign clr_addr_nxt = clr_addr_r + 1'b1;

  // The clearing pass owns the write port until every entry reads as zero.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_nxt;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clr_busy_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !(wr_en || rd_en))
    else $error("line store accessed during clearing pass");

  a_clear_covers_all: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_addr_r) == AW'(MAX_WIDTH - 1)))
    else $error("clearing pass ended before the last entry");

endmodule

// ----- design/wf3_lane.sv -----
// One color channel of the window filter: weighted sum, then divide or magnitude.
// Depends on wf3_pkg; three copies run side by side in the top level.
module wf3_lane (
  input  logic                          clk,
  input  logic                          ld,
  input  wf3_pkg::filt_mode_t           mode,
  input  wf3_pkg::win_t                 win,
  output logic [wf3_pkg::CH_W-1:0]      res
);
  import wf3_pkg::*;

  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;
  filt_mode_t              mode_r;
  logic [24:0]             prod;
  logic [SUM_W-1:0]        mag;

  function automatic logic signed [SUM_W-1:0] ext(input logic [CH_W-1:0] p);
    ext = $signed({{(SUM_W - CH_W){1'b0}}, p});
  endfunction

  always_comb begin
    unique case (mode)
      MODE_BOX: begin
        sum_nxt = ext(win[0]) + ext(win[1]) + ext(win[2]) + ext(win[3]) + ext(win[4])
                + ext(win[5]) + ext(win[6]) + ext(win[7]) + ext(win[8]);
      end
      MODE_SOBEL_X: begin
        sum_nxt = (ext(win[2]) + (ext(win[5]) <<< 1) + ext(win[8]))
                - (ext(win[0]) + (ext(win[3]) <<< 1) + ext(win[6]));
      end
      MODE_SOBEL_Y: begin
        sum_nxt = (ext(win[6]) + (ext(win[7]) <<< 1) + ext(win[8]))
                - (ext(win[0]) + (ext(win[1]) <<< 1) + ext(win[2]));
      end
      MODE_LAPL: begin
        sum_nxt = ext(win[1]) + ext(win[3]) + ext(win[5]) + ext(win[7])
                - (ext(win[4]) <<< 2);
      end
      default: sum_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      sum_r  <= sum_nxt;
      mode_r <= mode;
    end
  end

  // The box sum is never negative, so its low twelve bits carry it whole.
  assign prod = 25'(sum_r[11:0]) * 25'(BOX_RECIP);
  assign mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_comb begin
    if (mode_r == MODE_BOX) begin
      res = prod[BOX_SHIFT +: CH_W];
    end else if (mag > SUM_W'(255)) begin
      res = '1;
    end else begin
      res = mag[CH_W-1:0];
    end
  end

endmodule

// ----- design/window_filter_3x3_rgb.sv -----
// 3x3 window filter over a raster stream of packed BGR pixels (box, Sobel X/Y, Laplacian).
// A result is registered in stage 1, stage 2 and the output register before out_tvalid offers it.
// Throughput: one pixel per cycle unless stalled, as the line store reads and writes once per pixel.
// Reset: synchronous active-low rst_n; the line store then clears every entry with
// in_tready low, while configuration writes are taken at once.
// Depends on wf3_pkg, wf3_line_store and wf3_lane.
module window_filter_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input pixel channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [23:0] pixel_bgr
  input  logic        in_tuser,    // [0] frame_start
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [23:0] out_bgr, [33:24] out_x, [45:34] out_y, [47:46] zero
  output logic        out_tlast,   // out_last
  // Configuration writes.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import wf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > IW_W) ? AW + 1 : IW_W;

  // Configuration registers.
  filt_mode_t        mode_r;
  logic [IW_W-1:0]   cfg_width_r;
  logic [IH_W-1:0]   cfg_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_BOX;
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MODE:   mode_r       <= filt_mode_t'(cfg_wdata[1:0]);
        CFG_WIDTH:  cfg_width_r  <= cfg_wdata[IW_W-1:0];
        CFG_HEIGHT: cfg_height_r <= cfg_wdata[IH_W-1:0];
        CFG_NONE:   ;
        default:    ;
      endcase
    end
  end

  // Effective geometry: width clamped to [3, MAX_WIDTH], height to [3, 4096].
  logic [WW-1:0]   w_eff;
  logic [IH_W-1:0] h_eff;

  always_comb begin
    if (WW'(cfg_width_r) < WW'(3)) begin
      w_eff = WW'(3);
    end else if (WW'(cfg_width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (cfg_height_r < MIN_DIM_H) begin
      h_eff = MIN_DIM_H;
    end else if (cfg_height_r > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = cfg_height_r;
    end
  end

  // Pipeline handshakes. Each stage moves on when the stage after it is empty
  // or moving, so a finished result can wait while new pixels fill the empty stages behind it.
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_en, s2_en, s1_en, s1_adv, acc, ls_ready;

  assign out_en    = !out_v_r || out_tready;
  assign s2_en     = !s2_v_r || out_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign s1_adv    = s1_v_r && s2_en;
  assign in_tready = ls_ready && s1_en;
  assign acc       = in_tvalid && in_tready;

  // Position of the incoming pixel; frame_start forces it to the origin.
  logic [AW-1:0]    col_cnt_r, col_nxt, col;
  logic [ROW_W-1:0] row_cnt_r, row_nxt, row;
  logic [WW-1:0]    col_w;
  logic [IH_W-1:0]  row_h;
  logic             interior, last_px;

  assign col   = in_tuser ? '0 : col_cnt_r;
  assign row   = in_tuser ? '0 : row_cnt_r;
  assign col_w = WW'(col);
  assign row_h = IH_W'(row);

  assign interior = (col_w >= WW'(2)) && (row >= ROW_W'(2)) && (col_w < w_eff) && (row_h < h_eff);
  assign last_px  = (col_w == w_eff - WW'(1)) && (row_h == h_eff - IH_W'(1));

  always_comb begin
    if (col_w >= w_eff - WW'(1)) begin
      col_nxt = '0;
      row_nxt = (row_h >= h_eff - IH_W'(1)) ? '0 : row + 1'b1;
    end else begin
      col_nxt = col + 1'b1;
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc) begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // Stage 1: line store read data arrives. A pixel that follows another at the
  // same column (frame_start back to back) takes the older pixel's values
  // directly, since that write lands on the same edge as the new read.
  logic [PIX_W-1:0] s1_pix_r, s1_fwd_top_r, s1_fwd_mid_r;
  logic [AW-1:0]    s1_col_r;
  logic [OX_W-1:0]  s1_x_r;
  logic [OY_W-1:0]  s1_y_r;
  logic             s1_int_r, s1_last_r, s1_fwd_r;
  logic [LS_W-1:0]  ls_rd_data;
  logic [PIX_W-1:0] top_eff, mid_eff;

  assign top_eff = s1_fwd_r ? s1_fwd_top_r : ls_rd_data[LS_W-1:PIX_W];
  assign mid_eff = s1_fwd_r ? s1_fwd_mid_r : ls_rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r     <= in_tdata;
      s1_col_r     <= col;
      s1_x_r       <= OX_W'(col - 1'b1);
      s1_y_r       <= OY_W'(row - 1'b1);
      s1_int_r     <= interior;
      s1_last_r    <= last_px;
      s1_fwd_r     <= s1_v_r && (s1_col_r == col);
      s1_fwd_top_r <= mid_eff;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  wf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (col),
    .rd_data (ls_rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({mid_eff, s1_pix_r}),
    .ready   (ls_ready)
  );

  // Two previous window columns, top to bottom: left in 0..2, middle in 3..5.
  logic [5:0][PIX_W-1:0] wc_r;
  logic [2:0][PIX_W-1:0] cur;

  assign cur[0] = top_eff;
  assign cur[1] = mid_eff;
  assign cur[2] = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
    end else if (s1_adv) begin
      wc_r[2:0] <= wc_r[5:3];
      wc_r[5:3] <= cur;
    end
  end

  // Split the window into one 3x3 byte window per channel lane.
  win_t [N_CH-1:0] lane_win;

  always_comb begin
    for (int ch = 0; ch < N_CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        lane_win[ch][r*3]     = wc_r[r][ch*CH_W +: CH_W];
        lane_win[ch][r*3 + 1] = wc_r[3 + r][ch*CH_W +: CH_W];
        lane_win[ch][r*3 + 2] = cur[r][ch*CH_W +: CH_W];
      end
    end
  end

  // Stage 2: each lane holds its channel's weighted sum. Only interior pixels
  // go on to it; border pixels end at stage 1 after updating the stores and the window.
  logic [N_CH-1:0][CH_W-1:0] lane_res;
  logic [OX_W-1:0]           s2_x_r;
  logic [OY_W-1:0]           s2_y_r;
  logic                      s2_last_r;

  for (genvar g = 0; g < N_CH; g++) begin : g_lane
    wf3_lane u_lane (
      .clk  (clk),
      .ld   (s2_en),
      .mode (mode_r),
      .win  (lane_win[g]),
      .res  (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Output register: the merging stage packs the three lane results into one pixel.
  logic [PIX_W-1:0] out_bgr_r;
  logic [OX_W-1:0]  out_x_r;
  logic [OY_W-1:0]  out_y_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_bgr_r  <= lane_res;
      out_x_r    <= s2_x_r;
      out_y_r    <= s2_y_r;
      out_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= acc;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r && s1_int_r;
      end
      if (out_en) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_y_r, out_x_r, out_bgr_r};
  assign out_tlast  = out_last_r;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_v_r)
    else $error("accepted pixel did not reach stage 1");

  a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_en) |=> (s1_v_r && $stable(s1_col_r)))
    else $error("stage 1 lost its pixel while stalled");

  a_only_interior_results: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_v_r) |-> $past(s1_int_r))
    else $error("border pixel entered the filter stage");

endmodule

// ----- tb/wf3_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the 3x3 RGB window filter: a cycle-free predictor plus the queue of results it expects.
// Depends on wf3_pkg for widths, the filter mode enum and the register indexes.
package wf3_tb_pkg;
  import wf3_pkg::*;

  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned ROWS_MAX = 4096;

  typedef struct packed {
    logic [PIX_W-1:0] bgr;
    logic [OX_W-1:0]  x;
    logic [OY_W-1:0]  y;
    logic             last;
  } filt_result_t;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  class filter_scoreboard;
    filt_mode_t       mode;
    logic [IW_W-1:0]  width_reg;
    logic [IH_W-1:0]  height_reg;
    logic [PIX_W-1:0] row_older [LINE_MAX];
    logic [PIX_W-1:0] row_newer [LINE_MAX];
    logic [PIX_W-1:0] win_hist [6];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int               sobel_x_k [9];
    int               sobel_y_k [9];
    int               lapl_k [9];
    filt_result_t     want_q [$];
    int               errors;
    int               n_pixels;
    int               n_checked;

    function new();
      sobel_x_k = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
      sobel_y_k = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
      lapl_k    = '{0, 1, 0, 1, -4, 1, 0, 1, 0};
      mode = MODE_BOX;
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      foreach (row_older[i]) begin
        row_older[i] = '0;
        row_newer[i] = '0;
      end
      foreach (win_hist[i]) win_hist[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors = 0;
      n_pixels = 0;
      n_checked = 0;
    endfunction

    function void apply_register(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MODE:   mode = filt_mode_t'(val[1:0]);
        CFG_WIDTH:  width_reg = val[IW_W-1:0];
        CFG_HEIGHT: height_reg = val[IH_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // One 8-bit channel, px[r*3+c] with r = 0 the top row and c = 0 the left column.
    function logic [CH_W-1:0] filter_lane(int px [9]);
      int acc;
      acc = 0;
      for (int i = 0; i < 9; i++) begin
        case (mode)
          MODE_BOX:     acc += px[i];
          MODE_SOBEL_X: acc += px[i] * sobel_x_k[i];
          MODE_SOBEL_Y: acc += px[i] * sobel_y_k[i];
          default:      acc += px[i] * lapl_k[i];
        endcase
      end
      if (mode == MODE_BOX) return CH_W'(acc / 9);
      if (acc < 0) acc = -acc;
      if (acc > 255) acc = 255;
      return CH_W'(acc);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix, logic first);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      r;
      logic [PIX_W-1:0] top_px;
      logic [PIX_W-1:0] mid_px;
      logic [PIX_W-1:0] column9 [9];
      int               lane [9];
      filt_result_t     res;
      w = clamp_dim(width_reg, 3, LINE_MAX);
      h = clamp_dim(height_reg, 3, ROWS_MAX);
      if (first) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      top_px = '0;
      mid_px = '0;
      if (c < LINE_MAX) begin
        top_px = row_older[c];
        mid_px = row_newer[c];
        row_older[c] = mid_px;
        row_newer[c] = pix;
      end
      // Three window columns, oldest first, each listed top to bottom.
      for (int i = 0; i < 6; i++) column9[i] = win_hist[i];
      column9[6] = top_px;
      column9[7] = mid_px;
      column9[8] = pix;
      if (c >= 2 && r >= 2 && c < w && r < h) begin
        for (int ch = 0; ch < N_CH; ch++) begin
          for (int rr = 0; rr < 3; rr++)
            for (int cc = 0; cc < 3; cc++)
              lane[rr*3+cc] = int'(column9[cc*3+rr][ch*CH_W +: CH_W]);
          res.bgr[ch*CH_W +: CH_W] = filter_lane(lane);
        end
        res.x = OX_W'(c - 1);
        res.y = OY_W'(r - 1);
        res.last = (c == w - 1 && r == h - 1);
        want_q.push_back(res);
      end
      for (int i = 0; i < 6; i++) win_hist[i] = column9[i+3];
      if (c >= w - 1) begin
        col_pos = 0;
        row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
      n_pixels++;
    endfunction

    function void check_result(logic [47:0] data, logic last);
      filt_result_t want;
      if (want_q.size() == 0) begin
        $error("filtered pixel %h at x %0d y %0d arrived with no pixel pending",
               data[23:0], data[33:24], data[45:34]);
        errors++;
        return;
      end
      want = want_q.pop_front();
      n_checked++;
      if (data[23:0] !== want.bgr) begin
        $error("out_bgr: expected %h, actual %h", want.bgr, data[23:0]);
        errors++;
      end
      if (data[33:24] !== want.x) begin
        $error("out_x: expected %0d, actual %0d", want.x, data[33:24]);
        errors++;
      end
      if (data[45:34] !== want.y) begin
        $error("out_y: expected %0d, actual %0d", want.y, data[45:34]);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %b, actual %b", want.last, last);
        errors++;
      end
      if (data[47:46] !== 2'b00) begin
        $error("out_tdata padding: expected 0, actual %b", data[47:46]);
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_window_filter_3x3_rgb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for window_filter_3x3_rgb: streams BGR frames and compares every result.
// Depends on wf3_pkg and on the scoreboard in wf3_tb_pkg.
module tb_window_filter_3x3_rgb;
  import wf3_pkg::*;
  import wf3_tb_pkg::*;

  // The longest legal stretch without any transfer is the line store clear after reset;
  // receiver stalls and sender gaps are far shorter.
  localparam int IDLE_LIMIT    = 4000;
  // Pixels that produce no result can still be inside the three-stage pipeline after the
  // last result has left, so register writes wait a few cycles beyond the drain.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_PIXELS = 1000;
  localparam int FRAME_CAP     = 120;

  typedef enum logic [1:0] {
    FRAME_CLEAN,    // frame_start on the first pixel only
    FRAME_CHAINED,  // no frame_start at all, relies on the counters wrapping
    FRAME_NOISY     // frame_start on the first pixel and at random points
  } frame_kind_t;

  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_RANDOM,  // ready with probability three in four
    RX_BURSTY   // mostly ready, with occasional stalls
  } rx_style_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = CFG_NONE;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  filter_scoreboard  sb = new();

  // Sender state: bursts of random length separated by random gaps when gaps_on is set.
  bit                gaps_on = 1'b0;
  int                burst_left = 0;
  int                sent = 0;

  rx_style_t         rx_style = RX_OPEN;
  int                rx_left = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  window_filter_3x3_rgb #(
    .MAX_WIDTH (LINE_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Receiver: switches between stall styles at random intervals so that backpressure
  // lands on every pipeline phase, with open stretches in between.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 2));
      rx_left = $urandom_range(100, 400);
    end else begin
      rx_left--;
    end
    case (rx_style)
      RX_OPEN: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left != 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 15);
        end
      end
    endcase
  end

  // Monitor and watchdog. Both channels are sampled at the rising edge, so the values seen
  // here are the ones the block saw when it took the transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $error("no transfer on either channel for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random pixel; each channel is sometimes forced to all zeros or all ones so that the
  // saturating and maximum-sum paths are hit often.
  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] px;
    px = PIX_W'($urandom);
    for (int ch = 0; ch < N_CH; ch++)
      case ($urandom_range(0, 5))
        0: px[ch*CH_W +: CH_W] = '0;
        1: px[ch*CH_W +: CH_W] = '1;
        default: ;
      endcase
    return px;
  endfunction

  // Fixed content for the directed 3-wide frame: rows 0 to 2 all ones (largest box sum),
  // then a horizontal ramp, a dark row under bright rows (negative Sobel Y), and mixed values.
  function automatic logic [PIX_W-1:0] probe_pixel(int idx);
    case (idx)
      9:  return 24'h000000;
      10: return 24'h808080;
      11: return 24'hFFFFFF;
      12, 13, 14: return 24'h000000;
      15: return 24'h010203;
      16: return 24'h123456;
      17: return 24'h7F7F7F;
      18: return 24'hA5A5A5;
      19: return 24'h5A5A5A;
      20: return 24'h00FF00;
      21: return 24'hFF00FF;
      22: return 24'h0F0F0F;
      23: return 24'hF0F0F0;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // One pixel transfer. The valid is only lowered when a gap actually follows, so a pixel that
  // comes straight after the previous one keeps in_tvalid high without a glitch.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic first);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic stream_frame(input int unsigned n_px, input frame_kind_t kind);
    logic first;
    for (int unsigned i = 0; i < n_px; i++) begin
      first = (i == 0 && kind != FRAME_CHAINED) ||
              (kind == FRAME_NOISY && $urandom_range(0, 15) == 0);
      send_pixel(random_pixel(), first);
    end
  endtask

  // Stop sending and wait until every expected result has been taken, then let the pipeline
  // run empty. The extra edge first makes sure the monitor has seen the last pixel transfer.
  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Back-to-back writes keep cfg_wr_en high; end_writes drops it after the last one.
  task automatic set_register(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.apply_register(idx, val);
  endtask

  task automatic end_writes();
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned      w_eff;
    int unsigned      h_eff;
    int unsigned      n_px;
    int               phases;
    frame_kind_t      kind;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] hval;

    phases = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A few pixels under the reset geometry; the line store clear holds them off first.
    for (int i = 0; i < 3; i++) send_pixel(random_pixel(), i == 0);
    settle(SETTLE_CYCLES);

    // Directed part: a 3-wide, 8-high frame. Register values carry junk above the register
    // widths, and a write to the unused index must change nothing. Each of rows 2 to 5 gives
    // one result in its own mode; the last row closes the frame with out_last.
    set_register(CFG_MODE, 13'h1FFC);
    set_register(CFG_WIDTH, 13'h1803);
    set_register(CFG_HEIGHT, 13'd8);
    set_register(CFG_NONE, 13'h1FFF);
    end_writes();
    for (int i = 0; i < 24; i++) begin
      if (i == 9 || i == 12 || i == 15) begin
        settle(SETTLE_CYCLES);
        set_register(CFG_MODE, CFG_W'(i == 9 ? MODE_SOBEL_X : i == 12 ? MODE_SOBEL_Y : MODE_LAPL));
        end_writes();
      end
      send_pixel(probe_pixel(i), i == 0);
    end
    // Wrap at the frame end: the next frame starts without a frame_start marker.
    stream_frame(24, FRAME_CHAINED);

    // Random part: each phase drains the block (the sender pauses until every result is in),
    // picks a new geometry and mode, and sends a few frames of mixed kinds.
    while (sent < RANDOM_PIXELS) begin
      settle(SETTLE_CYCLES);
      gaps_on = ($urandom_range(0, 3) != 0);
      wval = CFG_W'($urandom_range(3, 12));
      hval = CFG_W'($urandom_range(3, 8));
      case ($urandom_range(0, 9))
        0: wval = CFG_W'($urandom_range(0, 2));
        1: hval = CFG_W'($urandom_range(0, 2));
        // Bits above the 11-bit width register must be dropped.
        2: wval = {2'($urandom_range(1, 3)), 11'($urandom_range(3, 12))};
        3: hval = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
        4: wval = 13'd1024;
        default: ;
      endcase
      set_register(CFG_MODE, CFG_W'($urandom));
      set_register(CFG_WIDTH, wval);
      set_register(CFG_HEIGHT, hval);
      if ($urandom_range(0, 4) == 0) set_register(CFG_NONE, CFG_W'($urandom));
      end_writes();
      w_eff = clamp_dim(wval[IW_W-1:0], 3, LINE_MAX);
      h_eff = clamp_dim(hval, 3, ROWS_MAX);

      repeat ($urandom_range(1, 3)) begin
        n_px = w_eff * h_eff;
        if (n_px > FRAME_CAP) n_px = $urandom_range(40, FRAME_CAP);
        kind = FRAME_CLEAN;
        case ($urandom_range(0, 9))
          0, 1: kind = FRAME_CHAINED;
          2: kind = FRAME_NOISY;
          3: n_px = $urandom_range(1, n_px);  // frame cut short
          default: ;
        endcase
        stream_frame(n_px, kind);
      end

      // Geometry change in the middle of a frame: the counters may now sit past the new
      // edge, which must give no result and wrap to the next row or to row 0.
      if ($urandom_range(0, 3) == 0) begin
        n_px = w_eff * h_eff;
        if (n_px > FRAME_CAP) n_px = FRAME_CAP;
        stream_frame($urandom_range(1, n_px), FRAME_CLEAN);
        settle(SETTLE_CYCLES);
        set_register(CFG_WIDTH, CFG_W'($urandom_range(3, 12)));
        set_register(CFG_HEIGHT, CFG_W'($urandom_range(3, 8)));
        end_writes();
        stream_frame($urandom_range(10, 100), FRAME_CHAINED);
      end
      phases++;
    end

    // The start of a frame at the widest line, reached through an out-of-range width that
    // clamps to the line store depth.
    settle(SETTLE_CYCLES);
    gaps_on = 1'b1;
    set_register(CFG_MODE, CFG_W'($urandom));
    set_register(CFG_WIDTH, 13'd2047);
    set_register(CFG_HEIGHT, 13'd3);
    end_writes();
    stream_frame(FRAME_CAP, FRAME_CLEAN);

    settle(DRAIN_CYCLES);
    $display("Streamed %0d pixels and checked %0d filtered results", sb.n_pixels, sb.n_checked);
    $display("Covered %0d random geometry phases plus directed and wide-line frames",
             phases);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
